// ===== hdl/qra_pkg.sv =====
// Shared types and term tables for the quaternion rotation accumulator.
// Used by the top level sequencer; no dependencies.
package qra_pkg;

    typedef enum logic [1:0] {
        OP_IDENT  = 2'd0,
        OP_MUL    = 2'd1,
        OP_NORM   = 2'd2,
        OP_MATRIX = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_Y = 2'd1,
        SEL_Z = 2'd2,
        SEL_W = 2'd3
    } sel_t;

    typedef struct packed {
        sel_t a;
        sel_t b;
        logic neg;
        logic one;
    } term_t;

    // Hamilton product terms, four per output component (x, y, z, w).
    function automatic term_t ham_term(input logic [3:0] idx);
        term_t t;
        t.one = 1'b0;
        t.neg = 1'b0;
        t.a   = SEL_X;
        unique case (idx[1:0])
            2'd0:    t.b = SEL_W;
            2'd1:    t.b = SEL_X;
            2'd2:    t.b = SEL_Y;
            default: t.b = SEL_Z;
        endcase
        unique case (idx)
            4'd0:  t.a = SEL_X;
            4'd1:  t.a = SEL_W;
            4'd2:  t.a = SEL_Z;
            4'd3:  begin t.a = SEL_Y; t.neg = 1'b1; end
            4'd4:  t.a = SEL_Y;
            4'd5:  begin t.a = SEL_Z; t.neg = 1'b1; end
            4'd6:  t.a = SEL_W;
            4'd7:  t.a = SEL_X;
            4'd8:  t.a = SEL_Z;
            4'd9:  t.a = SEL_Y;
            4'd10: begin t.a = SEL_X; t.neg = 1'b1; end
            4'd11: t.a = SEL_W;
            4'd12: t.a = SEL_W;
            4'd13: begin t.a = SEL_X; t.neg = 1'b1; end
            4'd14: begin t.a = SEL_Y; t.neg = 1'b1; end
            default: begin t.a = SEL_Z; t.neg = 1'b1; end
        endcase
        return t;
    endfunction

    // Rotation matrix terms, two per entry; the entry sits in idx[4:1].
    function automatic term_t mat_term(input logic [4:0] idx);
        term_t t;
        t.a   = SEL_X;
        t.b   = SEL_X;
        t.neg = 1'b0;
        t.one = 1'b0;
        unique case (idx)
            5'd0:  begin t.a = SEL_Y; t.b = SEL_Y; t.neg = 1'b1; t.one = 1'b1; end
            5'd1:  begin t.a = SEL_Z; t.b = SEL_Z; t.neg = 1'b1; t.one = 1'b1; end
            5'd2:  begin t.a = SEL_X; t.b = SEL_Y; end
            5'd3:  begin t.a = SEL_Z; t.b = SEL_W; t.neg = 1'b1; end
            5'd4:  begin t.a = SEL_X; t.b = SEL_Z; end
            5'd5:  begin t.a = SEL_Y; t.b = SEL_W; end
            5'd6:  begin t.a = SEL_X; t.b = SEL_Y; end
            5'd7:  begin t.a = SEL_Z; t.b = SEL_W; end
            5'd8:  begin t.a = SEL_X; t.b = SEL_X; t.neg = 1'b1; t.one = 1'b1; end
            5'd9:  begin t.a = SEL_Z; t.b = SEL_Z; t.neg = 1'b1; t.one = 1'b1; end
            5'd10: begin t.a = SEL_Y; t.b = SEL_Z; end
            5'd11: begin t.a = SEL_X; t.b = SEL_W; t.neg = 1'b1; end
            5'd12: begin t.a = SEL_X; t.b = SEL_Z; end
            5'd13: begin t.a = SEL_Y; t.b = SEL_W; t.neg = 1'b1; end
            5'd14: begin t.a = SEL_Y; t.b = SEL_Z; end
            5'd15: begin t.a = SEL_X; t.b = SEL_W; end
            5'd16: begin t.a = SEL_X; t.b = SEL_X; t.neg = 1'b1; t.one = 1'b1; end
            5'd17: begin t.a = SEL_Y; t.b = SEL_Y; t.neg = 1'b1; t.one = 1'b1; end
            default: begin t.a = SEL_X; t.b = SEL_X; end
        endcase
        return t;
    endfunction

endpackage

// ===== hdl/quaternion_rotation_accumulator.sv =====
// Quaternion rotation accumulator: one word at a time, s_ready only when idle.
// Identity loads the identity quaternion directly from idle. Multiply: 16 products through the shared multiplier.
// Normalize: four squares, then the bit-serial root, then one divide per component
// (divides skipped for a zero length); matrix output adds 18 products before m_valid.
// Synchronous active-low reset clears the sequencer and sets the quaternion to identity.
// Depends on qra_pkg, qra_mul, qra_isqrt, qra_div.
module quaternion_rotation_accumulator #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic signed [WORD_WIDTH-1:0] s_in_x,
    input  logic signed [WORD_WIDTH-1:0] s_in_y,
    input  logic signed [WORD_WIDTH-1:0] s_in_z,
    input  logic signed [WORD_WIDTH-1:0] s_in_w,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [WORD_WIDTH-1:0] m_row0_col0,
    output logic signed [WORD_WIDTH-1:0] m_row0_col1,
    output logic signed [WORD_WIDTH-1:0] m_row0_col2,
    output logic signed [WORD_WIDTH-1:0] m_row1_col0,
    output logic signed [WORD_WIDTH-1:0] m_row1_col1,
    output logic signed [WORD_WIDTH-1:0] m_row1_col2,
    output logic signed [WORD_WIDTH-1:0] m_row2_col0,
    output logic signed [WORD_WIDTH-1:0] m_row2_col1,
    output logic signed [WORD_WIDTH-1:0] m_row2_col2
);
    import qra_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2 * W + 2;
    localparam int NB = W + F;
    localparam int AW = ((2 * W > 2 * F) ? 2 * W : 2 * F) + 4;

    localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_W = (F >= W - 1) ? W_MAX : (W'(1) << F);
    localparam logic signed [AW-1:0] ONE2 = {{(AW-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};
    localparam logic signed [AW-1:0] HALF = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic [NB-1:0] Q_MAX = {{(NB-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [NB-1:0] Q_MIN = {{(NB-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_HMUL, ST_HACC, ST_HCOMMIT, ST_NMUL, ST_NACC, ST_SQ_GO, ST_SQ_WAIT,
        ST_DV_GO, ST_DV_WAIT, ST_NCOMMIT, ST_MMUL, ST_MACC, ST_OUT
    } state_t;

    state_t                state_reg;
    opcode_t               op_reg;
    logic signed [W-1:0]   in_reg  [4];
    logic signed [W-1:0]   cur_reg [4];
    logic signed [W-1:0]   nq_reg  [4];
    logic signed [W-1:0]   res_reg [9];
    logic signed [AW-1:0]  acc_reg;
    logic [4:0]            step_reg;
    logic [W:0]            len_reg;

    term_t                 ht;
    term_t                 mt;
    logic signed [W-1:0]   mul_a;
    logic signed [W-1:0]   mul_b;
    logic signed [2*W-1:0] prod;
    logic signed [AW-1:0]  pext;
    logic signed [AW-1:0]  base;
    logic signed [AW-1:0]  addend;
    logic                  sub;
    logic signed [AW-1:0]  acc_next;
    logic signed [W-1:0]   rnd;
    logic signed [W-1:0]   dv_c;
    logic [W-1:0]          dv_mag;
    logic                  sq_start;
    logic                  sq_done;
    logic [W:0]            sq_root;
    logic                  dv_start;
    logic                  dv_done;
    logic [NB-1:0]         dv_quo;
    logic signed [W-1:0]   dv_res;

    function automatic logic signed [W-1:0] round_sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        r = (v + HALF) >>> F;
        if (r[AW-1:W-1] == '0 || r[AW-1:W-1] == '1) begin
            return r[W-1:0];
        end
        return r[AW-1] ? W_MIN : W_MAX;
    endfunction

    always_comb begin
        ht   = ham_term(step_reg[3:0]);
        mt   = mat_term(step_reg);
        pext = {{(AW-2*W){prod[2*W-1]}}, prod};
        case (state_reg)
            ST_HMUL: begin
                mul_a = in_reg[ht.a];
                mul_b = cur_reg[ht.b];
            end
            ST_MMUL: begin
                mul_a = cur_reg[mt.a];
                mul_b = cur_reg[mt.b];
            end
            default: begin
                mul_a = cur_reg[step_reg[1:0]];
                mul_b = cur_reg[step_reg[1:0]];
            end
        endcase
        case (state_reg)
            ST_HACC: begin
                base   = acc_reg;
                addend = pext;
                sub    = ht.neg;
            end
            ST_MACC: begin
                base   = step_reg[0] ? acc_reg : (mt.one ? ONE2 : '0);
                addend = pext <<< 1;
                sub    = mt.neg;
            end
            default: begin
                base   = acc_reg;
                addend = pext;
                sub    = 1'b0;
            end
        endcase
        acc_next = sub ? (base - addend) : (base + addend);
        rnd      = round_sat(acc_next);
        dv_c     = cur_reg[step_reg[1:0]];
        dv_mag   = dv_c[W-1] ? (W'(0) - dv_c) : dv_c;
        if (dv_c[W-1]) begin
            dv_res = (dv_quo > Q_MIN) ? W_MIN : (W'(0) - dv_quo[W-1:0]);
        end else begin
            dv_res = (dv_quo > Q_MAX) ? W_MAX : dv_quo[W-1:0];
        end
        sq_start = (state_reg == ST_SQ_GO);
        dv_start = (state_reg == ST_DV_GO);
    end

    qra_mul #(.W(W)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    qra_isqrt #(.W(W)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (acc_reg[SW-1:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    qra_div #(.W(W), .F(F)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .num     ({dv_mag, {F{1'b0}}}),
        .den     (len_reg),
        .done    (dv_done),
        .quo     (dv_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cur_reg[0] <= '0;
            cur_reg[1] <= '0;
            cur_reg[2] <= '0;
            cur_reg[3] <= ONE_W;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= opcode_t'(s_opcode);
                        in_reg[0] <= s_in_x;
                        in_reg[1] <= s_in_y;
                        in_reg[2] <= s_in_z;
                        in_reg[3] <= s_in_w;
                        step_reg  <= '0;
                        acc_reg   <= '0;
                        unique case (opcode_t'(s_opcode))
                            OP_IDENT: begin
                                cur_reg[0] <= '0;
                                cur_reg[1] <= '0;
                                cur_reg[2] <= '0;
                                cur_reg[3] <= ONE_W;
                            end
                            OP_MUL:                state_reg <= ST_HMUL;
                            OP_NORM, OP_MATRIX:    state_reg <= ST_NMUL;
                            default:               state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_HMUL: state_reg <= ST_HACC;
                ST_HACC: begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 5'd1;
                    state_reg <= ST_HMUL;
                    if (step_reg[1:0] == 2'd3) begin
                        nq_reg[step_reg[3:2]] <= rnd;
                        acc_reg <= '0;
                        if (step_reg[3:2] == 2'd3) begin
                            state_reg <= ST_HCOMMIT;
                        end
                    end
                end
                ST_HCOMMIT: begin
                    cur_reg   <= nq_reg;
                    state_reg <= ST_IDLE;
                end
                ST_NMUL: state_reg <= ST_NACC;
                ST_NACC: begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 5'd1;
                    state_reg <= (step_reg[1:0] == 2'd3) ? ST_SQ_GO : ST_NMUL;
                end
                ST_SQ_GO: state_reg <= ST_SQ_WAIT;
                ST_SQ_WAIT: begin
                    if (sq_done) begin
                        len_reg  <= sq_root;
                        step_reg <= '0;
                        if (sq_root == '0) begin
                            state_reg <= (op_reg == OP_MATRIX) ? ST_MMUL : ST_IDLE;
                        end else begin
                            state_reg <= ST_DV_GO;
                        end
                    end
                end
                ST_DV_GO: state_reg <= ST_DV_WAIT;
                ST_DV_WAIT: begin
                    if (dv_done) begin
                        nq_reg[step_reg[1:0]] <= dv_res;
                        step_reg <= step_reg + 5'd1;
                        state_reg <= (step_reg[1:0] == 2'd3) ? ST_NCOMMIT : ST_DV_GO;
                    end
                end
                ST_NCOMMIT: begin
                    cur_reg   <= nq_reg;
                    step_reg  <= '0;
                    state_reg <= (op_reg == OP_MATRIX) ? ST_MMUL : ST_IDLE;
                end
                ST_MMUL: state_reg <= ST_MACC;
                ST_MACC: begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 5'd1;
                    state_reg <= ST_MMUL;
                    if (step_reg[0]) begin
                        res_reg[step_reg[4:1]] <= rnd;
                        if (step_reg == 5'd17) begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_OUT);
    assign m_row0_col0 = res_reg[0];
    assign m_row0_col1 = res_reg[1];
    assign m_row0_col2 = res_reg[2];
    assign m_row1_col0 = res_reg[3];
    assign m_row1_col1 = res_reg[4];
    assign m_row1_col2 = res_reg[5];
    assign m_row2_col0 = res_reg[6];
    assign m_row2_col1 = res_reg[7];
    assign m_row2_col2 = res_reg[8];
endmodule

// ===== hdl/qra_mul.sv =====
// Shared signed multiplier with registered product.
// No dependencies.
module qra_mul #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);
    logic signed [2*W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

// ===== hdl/qra_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// No dependencies.
module qra_isqrt #(
    parameter int W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [2*W+1:0]    radicand,
    output logic              done,
    output logic [W:0]        root
);
    localparam int SW = 2 * W + 2;
    localparam int RW = W + 1;
    localparam int CW = $clog2(RW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] s_reg;
    logic [RW-1:0] root_reg;
    logic [RW:0]   rem_reg;
    logic [RW+2:0] rsh;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          fits;

    always_comb begin
        rsh   = {rem_reg, s_reg[SW-1:SW-2]};
        trial = {1'b0, root_reg, 2'b01};
        diff  = rsh - trial;
        fits  = (rsh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
                s_reg    <= radicand;
                root_reg <= '0;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                s_reg    <= {s_reg[SW-3:0], 2'b00};
                root_reg <= {root_reg[RW-2:0], fits};
                rem_reg  <= fits ? diff[RW:0] : rsh[RW:0];
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== hdl/qra_div.sv =====
// Restoring long divider, one quotient bit per cycle.
// No dependencies.
module qra_div #(
    parameter int W = 32,
    parameter int F = 30
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [W+F-1:0]   num,
    input  logic [W:0]       den,
    output logic             done,
    output logic [W+F-1:0]   quo
);
    localparam int NB = W + F;
    localparam int CW = $clog2(NB + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NB-1:0] num_reg;
    logic [NB-1:0] quo_reg;
    logic [W:0]    rem_reg;
    logic [W+1:0]  rem_sh;
    logic [W+1:0]  diff;
    logic          fits;

    always_comb begin
        rem_sh = {rem_reg, num_reg[NB-1]};
        diff   = rem_sh - {1'b0, den};
        fits   = (rem_sh >= {1'b0, den});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
                num_reg  <= num;
                quo_reg  <= '0;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[NB-2:0], 1'b0};
                quo_reg <= {quo_reg[NB-2:0], fits};
                rem_reg <= fits ? diff[W:0] : rem_sh[W:0];
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== tb/sv/quaternion_rotation_accumulator_test.sv =====
// Self-checking testbench for the quaternion rotation accumulator: identity, multiply, normalise
// and matrix words are predicted in exact wide arithmetic; matrices are compared field by field.
// Depends on qra_pkg and quaternion_rotation_accumulator.
module quaternion_rotation_accumulator_test;
    import qra_pkg::*;

    localparam int W = 32;
    localparam int F = 30;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_Q = 32'sd1073741824;
    localparam longint unsigned CYCLE_LIMIT = 2_000_000;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [W-1:0] word_t;
    typedef struct {
        word_t e [9];
    } rotation_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_opcode = OP_IDENT;
    word_t s_in_x = '0, s_in_y = '0, s_in_z = '0, s_in_w = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    word_t m_row0_col0, m_row0_col1, m_row0_col2, m_row1_col0, m_row1_col1;
    word_t m_row1_col2, m_row2_col0, m_row2_col1, m_row2_col2;

    word_t q_x, q_y, q_z, q_w;
    rotation_t matrix_queue [$];
    int fail_count = 0;
    longint unsigned cycle_count = 0;

    quaternion_rotation_accumulator #(.WORD_WIDTH(W), .FRAC_BITS(F)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_in_x(s_in_x), .s_in_y(s_in_y), .s_in_z(s_in_z), .s_in_w(s_in_w),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_row0_col0(m_row0_col0), .m_row0_col1(m_row0_col1), .m_row0_col2(m_row0_col2),
        .m_row1_col0(m_row1_col0), .m_row1_col1(m_row1_col1), .m_row1_col2(m_row1_col2),
        .m_row2_col0(m_row2_col0), .m_row2_col1(m_row2_col1), .m_row2_col2(m_row2_col2)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic wide_t wprod(word_t a, word_t b);
        wide_t pa, pb;
        pa = a;
        pb = b;
        return pa * pb;
    endfunction

    function automatic word_t clamp_word(wide_t v);
        if (v > wide_t'(WMAX)) return WMAX;
        if (v < wide_t'(WMIN)) return WMIN;
        return v[W-1:0];
    endfunction

    function automatic word_t round_word(wide_t v);
        return clamp_word((v + (wide_t'(1) <<< (F - 1))) >>> F);
    endfunction

    function automatic logic [127:0] root_floor(logic [127:0] s);
        logic [127:0] r, c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    function automatic word_t scale_component(word_t c, logic [127:0] len);
        logic [127:0] mag, quo;
        mag = c[W-1] ? -wide_t'(c) : wide_t'(c);
        quo = (mag << F) / len;
        if (c[W-1]) return (quo > (128'd1 << (W - 1))) ? WMIN : word_t'(-quo);
        return (quo > 128'(WMAX)) ? WMAX : word_t'(quo);
    endfunction

    task automatic normalise_quaternion();
        logic [127:0] len;
        len = root_floor(wprod(q_x, q_x) + wprod(q_y, q_y) + wprod(q_z, q_z)
                         + wprod(q_w, q_w));
        if (len != 0) begin
            q_x = scale_component(q_x, len);
            q_y = scale_component(q_y, len);
            q_z = scale_component(q_z, len);
            q_w = scale_component(q_w, len);
        end
    endtask

    task automatic predict_orientation(opcode_t op, word_t ix, word_t iy, word_t iz,
                                       word_t iw);
        wide_t nx, ny, nz, nw, xx, xy, xz, xw, yy, yz, yw, zz, zw, one2;
        rotation_t r;
        case (op)
            OP_IDENT: begin
                q_x = '0; q_y = '0; q_z = '0; q_w = ONE_Q;
            end
            OP_MUL: begin
                nx = wprod(ix, q_w) + wprod(iw, q_x) + wprod(iz, q_y) - wprod(iy, q_z);
                ny = wprod(iy, q_w) - wprod(iz, q_x) + wprod(iw, q_y) + wprod(ix, q_z);
                nz = wprod(iz, q_w) + wprod(iy, q_x) - wprod(ix, q_y) + wprod(iw, q_z);
                nw = wprod(iw, q_w) - wprod(ix, q_x) - wprod(iy, q_y) - wprod(iz, q_z);
                q_x = round_word(nx); q_y = round_word(ny);
                q_z = round_word(nz); q_w = round_word(nw);
            end
            OP_NORM: normalise_quaternion();
            default: begin
                normalise_quaternion();
                xx = wprod(q_x, q_x); xy = wprod(q_x, q_y); xz = wprod(q_x, q_z);
                xw = wprod(q_x, q_w); yy = wprod(q_y, q_y); yz = wprod(q_y, q_z);
                yw = wprod(q_y, q_w); zz = wprod(q_z, q_z); zw = wprod(q_z, q_w);
                one2 = wide_t'(1) <<< (2 * F);
                r.e[0] = round_word(one2 - 2 * (yy + zz));
                r.e[1] = round_word(2 * (xy - zw));
                r.e[2] = round_word(2 * (xz + yw));
                r.e[3] = round_word(2 * (xy + zw));
                r.e[4] = round_word(one2 - 2 * (xx + zz));
                r.e[5] = round_word(2 * (yz - xw));
                r.e[6] = round_word(2 * (xz - yw));
                r.e[7] = round_word(2 * (yz + xw));
                r.e[8] = round_word(one2 - 2 * (xx + yy));
                matrix_queue.push_back(r);
            end
        endcase
    endtask

    task automatic report_mismatch(string what, word_t got, word_t want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    task automatic send_word(opcode_t op, word_t ix, word_t iy, word_t iz, word_t iw);
        int idle;
        idle = $urandom_range(0, 7);
        if (idle != 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_in_x <= ix; s_in_y <= iy; s_in_z <= iz; s_in_w <= iw;
        do @(posedge aclk); while (!s_ready);
        predict_orientation(op, ix, iy, iz, iw);
    endtask

    // hold ready low for a random count, then wait for the word
    initial begin
        word_t got [9];
        rotation_t want;
        int idle;
        forever begin
            idle = $urandom_range(0, 7);
            if (idle != 0) begin
                m_ready <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_row0_col0, m_row0_col1, m_row0_col2, m_row1_col0, m_row1_col1,
                    m_row1_col2, m_row2_col0, m_row2_col1, m_row2_col2};
            if (matrix_queue.size() == 0) begin
                report_mismatch("unexpected matrix", got[0], '0);
            end else begin
                want = matrix_queue.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.e[i]) report_mismatch($sformatf("entry %0d", i),
                                                              got[i], want.e[i]);
            end
        end
    end

    function automatic word_t rand_word();
        case ($urandom_range(0, 5))
            0: return WMAX;
            1: return WMIN;
            2: return word_t'($urandom_range(0, 2**F)) - word_t'($urandom_range(0, 2**F));
            3: return word_t'($urandom_range(0, 2**(F-2))) - (2**(F-3));
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_word(OP_MATRIX, WMAX, WMIN, WMAX, WMIN);
        send_word(OP_MUL, ONE_Q, 0, 0, 0);
        send_word(OP_MATRIX, 0, 0, 0, 0);
        send_word(OP_MUL, WMAX, WMAX, WMAX, WMAX);
        send_word(OP_MUL, WMIN, WMIN, WMIN, WMIN);
        send_word(OP_MUL, WMAX, WMIN, WMAX, WMIN);
        send_word(OP_NORM, -1, -1, -1, -1);
        send_word(OP_MATRIX, 0, 0, 0, 0);
        // zero length: state holds, matrix of the zero quaternion
        send_word(OP_MUL, 0, 0, 0, 0);
        send_word(OP_NORM, 0, 0, 0, 0);
        send_word(OP_MATRIX, 0, 0, 0, 0);
        send_word(OP_IDENT, WMAX, WMIN, -1, 1);
        send_word(OP_MUL, 1, -1, 1, -1);
        send_word(OP_MATRIX, 0, 0, 0, 0);
        send_word(OP_IDENT, 0, 0, 0, 0);
        send_word(OP_MUL, 0, 0, 0, WMIN);
        send_word(OP_MATRIX, 0, 0, 0, 0);
    endtask

    task automatic test_random();
        int r;
        for (int n = 0; n < 1700; n++) begin
            r = $urandom_range(0, 9);
            if (r == 0) send_word(OP_IDENT, rand_word(), rand_word(), rand_word(), rand_word());
            else if (r < 6) send_word(OP_MUL, rand_word(), rand_word(), rand_word(),
                                      rand_word());
            else if (r < 7) send_word(OP_NORM, rand_word(), rand_word(), rand_word(),
                                      rand_word());
            else send_word(OP_MATRIX, rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    initial begin
        q_x = '0; q_y = '0; q_z = '0; q_w = ONE_Q;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        s_valid <= 1'b0;
        while (matrix_queue.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/qra_pkg.sv
hdl/qra_mul.sv
hdl/qra_isqrt.sv
hdl/qra_div.sv
hdl/quaternion_rotation_accumulator.sv
tb/sv/quaternion_rotation_accumulator_test.sv
